>>> src/tcc_pkg.sv
package tcc_pkg;

   // Largest screen the cursor registers can address
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS = 128;
   localparam int COL_LIMIT = (MAX_COLUMNS < 1) ? 1 : ((MAX_COLUMNS < 256) ? MAX_COLUMNS : 256);
   localparam int ROW_LIMIT = (MAX_ROWS < 1) ? 1 : ((MAX_ROWS < 128) ? MAX_ROWS : 128);

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Request codes
   localparam logic [2:0] REQ_WRITE = 3'd0;
   localparam logic [2:0] REQ_BACKSPACE = 3'd1;
   localparam logic [2:0] REQ_ERASE = 3'd2;
   localparam logic [2:0] REQ_CLEAR = 3'd3;
   localparam logic [2:0] REQ_SET_CURSOR = 3'd4;

   // Action codes
   localparam logic [1:0] ACT_DRAW = 2'd0;
   localparam logic [1:0] ACT_SCROLL = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_COLUMNS = 2'd0;
   localparam logic [1:0] REG_ROWS = 2'd1;
   localparam logic [1:0] REG_FG = 2'd2;
   localparam logic [1:0] REG_BG = 2'd3;

   localparam logic [8:0] COLUMNS_RESET = 9'd128;
   localparam logic [7:0] ROWS_RESET = 8'd48;
   localparam logic [3:0] FG_RESET = 4'd15;
   localparam logic [3:0] BG_RESET = 4'd0;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  cell_col;
      logic [6:0]  cell_row;
      logic [7:0]  glyph_code;
      logic [23:0] fg_rgb;
      logic [23:0] bg_rgb;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
      logic [7:0] col;
      logic [6:0] row;
   } step_type;

   function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0: rgb = 24'h000000;
         4'd1: rgb = 24'h0000AA;
         4'd2: rgb = 24'h00AA00;
         4'd3: rgb = 24'h00AAAA;
         4'd4: rgb = 24'hAA0000;
         4'd5: rgb = 24'hAA00AA;
         4'd6: rgb = 24'hAA5500;
         4'd7: rgb = 24'hAAAAAA;
         4'd8: rgb = 24'h555555;
         4'd9: rgb = 24'h5555FF;
         4'd10: rgb = 24'h55FF55;
         4'd11: rgb = 24'h55FFFF;
         4'd12: rgb = 24'hFF5555;
         4'd13: rgb = 24'hFF55FF;
         4'd14: rgb = 24'hFFFF55;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

endpackage

>>> src/tcc_step.sv
module tcc_step (
   input  logic [2:0]          req_type,
   input  logic [7:0]          char_code,
   input  logic signed [15:0]  target_col,
   input  logic signed [15:0]  target_row,
   input  logic [7:0]          cur_col,
   input  logic [6:0]          cur_row,
   input  logic [8:0]          cols_eff,
   input  logic [7:0]          rows_eff,
   input  logic [3:0]          fg_idx,
   input  logic [3:0]          bg_idx,
   output tcc_pkg::step_type   step
);

   logic [7:0]       bs_col;
   logic             row_ok;
   logic             draw_ok;
   logic             bs_draw_ok;
   logic [8:0]       col_inc;
   logic [7:0]       row_inc;
   logic             wrap_scroll;
   logic [7:0]       wrap_row;
   logic [8:0]       cols_m1;
   logic [7:0]       rows_m1;
   tcc_pkg::rsp_type scroll_rsp;
   tcc_pkg::rsp_type clear_rsp;
   tcc_pkg::rsp_type draw_rsp;

   assign bs_col = cur_col - 8'd1;
   assign row_ok = {1'b0, cur_row} < rows_eff;
   assign draw_ok = ({1'b0, cur_col} < cols_eff) && row_ok;
   assign bs_draw_ok = ({1'b0, bs_col} < cols_eff) && row_ok;
   assign col_inc = {1'b0, cur_col} + 9'd1;
   assign row_inc = {1'b0, cur_row} + 8'd1;
   assign cols_m1 = cols_eff - 9'd1;
   assign rows_m1 = rows_eff - 8'd1;
   assign wrap_scroll = row_inc >= rows_eff;
   assign wrap_row = wrap_scroll ? rows_m1 : row_inc;

   always_comb begin
      scroll_rsp = '0;
      scroll_rsp.action = tcc_pkg::ACT_SCROLL;
      clear_rsp = '0;
      clear_rsp.action = tcc_pkg::ACT_CLEAR;
      draw_rsp.action = tcc_pkg::ACT_DRAW;
      draw_rsp.cell_col = cur_col;
      draw_rsp.cell_row = cur_row;
      draw_rsp.glyph_code = tcc_pkg::CHAR_SPACE;
      draw_rsp.fg_rgb = tcc_pkg::palette_rgb(fg_idx);
      draw_rsp.bg_rgb = tcc_pkg::palette_rgb(bg_idx);
      draw_rsp.last = 1'b0;
   end

   always_comb begin
      step = '0;
      step.col = cur_col;
      step.row = cur_row;
      case (req_type)
         tcc_pkg::REQ_WRITE: begin
            if (char_code == tcc_pkg::CHAR_NEWLINE) begin
               step.col = 8'd0;
               step.row = wrap_row[6:0];
               if (wrap_scroll) begin
                  step.first = scroll_rsp;
                  step.count = 2'd1;
               end
            end else begin
               if (draw_ok) begin
                  step.first = draw_rsp;
                  step.first.glyph_code = char_code;
                  step.count = 2'd1;
               end
               if (col_inc >= cols_eff) begin
                  step.col = 8'd0;
                  step.row = wrap_row[6:0];
                  if (wrap_scroll) begin
                     if (draw_ok) begin
                        step.second = scroll_rsp;
                        step.count = 2'd2;
                     end else begin
                        step.first = scroll_rsp;
                        step.count = 2'd1;
                     end
                  end
               end else begin
                  step.col = col_inc[7:0];
               end
            end
         end
         tcc_pkg::REQ_BACKSPACE: begin
            if (cur_col != 8'd0) begin
               step.col = bs_col;
               if (bs_draw_ok) begin
                  step.first = draw_rsp;
                  step.first.cell_col = bs_col;
                  step.count = 2'd1;
               end
            end
         end
         tcc_pkg::REQ_ERASE: begin
            if (draw_ok) begin
               step.first = draw_rsp;
               step.count = 2'd1;
            end
         end
         tcc_pkg::REQ_CLEAR: begin
            step.first = clear_rsp;
            step.count = 2'd1;
            step.col = 8'd0;
            step.row = 7'd0;
         end
         tcc_pkg::REQ_SET_CURSOR: begin
            // clamp each signed coordinate into the screen
            if (target_col[15]) begin
               step.col = 8'd0;
            end else if ($unsigned(target_col) >= {7'd0, cols_eff}) begin
               step.col = cols_m1[7:0];
            end else begin
               step.col = target_col[7:0];
            end
            if (target_row[15]) begin
               step.row = 7'd0;
            end else if ($unsigned(target_row) >= {8'd0, rows_eff}) begin
               step.row = rows_m1[6:0];
            end else begin
               step.row = target_row[6:0];
            end
         end
         default: begin
            step.count = 2'd0;
         end
      endcase
      // mark the final result of this request
      if (step.count == 2'd1) begin
         step.first.last = 1'b1;
      end
      if (step.count == 2'd2) begin
         step.second.last = 1'b1;
      end
   end

endmodule

>>> src/tcc_rsp_fifo.sv
module tcc_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         push_count,
   input  tcc_pkg::rsp_type                   push_first,
   input  tcc_pkg::rsp_type                   push_second,
   input  logic                               pop,
   output logic [tcc_pkg::FIFO_CNT_W-1:0]     count,
   output tcc_pkg::rsp_type                   head
);

   tcc_pkg::rsp_type                    mem [tcc_pkg::FIFO_DEPTH];
   logic [tcc_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tcc_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tcc_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic [tcc_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + tcc_pkg::FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + tcc_pkg::FIFO_PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + tcc_pkg::FIFO_PTR_W'(pop);
   assign count_in = count_ff + tcc_pkg::FIFO_CNT_W'(push_count)
                     - tcc_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;
   assign head = mem[rd_ptr_ff];

endmodule

>>> src/text_console_cursor_controller.sv
// Text console cursor controller. Each request is decoded against the cursor
// registers in the cycle it is accepted and yields zero, one or two results
// (draw cell, scroll up one text row, clear screen) that enter a four-entry
// result queue. A request is taken every cycle while the queue has room for
// two results; the result port drains one result per cycle while rsp_stall
// is low. Results appear on the rsp_ port in the cycle after the request is
// accepted at the earliest. Registers at byte addresses 0, 4, 8 and 12:
// screen columns, screen rows, foreground and background palette index;
// write them only while no request is in flight.
module text_console_cursor_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_type,
   input  logic [7:0]          req_char_code,
   input  logic signed [15:0]  req_target_col,
   input  logic signed [15:0]  req_target_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_action,
   output logic [7:0]          rsp_cell_col,
   output logic [6:0]          rsp_cell_row,
   output logic [7:0]          rsp_glyph_code,
   output logic [23:0]         rsp_fg_rgb,
   output logic [23:0]         rsp_bg_rgb,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [8:0] COL_LIMIT_V = 9'(tcc_pkg::COL_LIMIT);
   localparam logic [7:0] ROW_LIMIT_V = 8'(tcc_pkg::ROW_LIMIT);

   logic [8:0]                      cols_ff;
   logic [7:0]                      rows_ff;
   logic [3:0]                      fg_ff;
   logic [3:0]                      bg_ff;
   logic [7:0]                      cur_col_ff;
   logic [6:0]                      cur_row_ff;
   logic [8:0]                      cols_eff;
   logic [7:0]                      rows_eff;
   logic                            csr_write;
   logic                            req_fire;
   logic                            rsp_fire;
   logic [1:0]                      push_count;
   logic [tcc_pkg::FIFO_CNT_W-1:0]  fifo_count;
   tcc_pkg::step_type               step;
   tcc_pkg::rsp_type                head;

   // Configuration port
   assign pready = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= tcc_pkg::COLUMNS_RESET;
         rows_ff <= tcc_pkg::ROWS_RESET;
         fg_ff <= tcc_pkg::FG_RESET;
         bg_ff <= tcc_pkg::BG_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            tcc_pkg::REG_COLUMNS: cols_ff <= pwdata[8:0];
            tcc_pkg::REG_ROWS: rows_ff <= pwdata[7:0];
            tcc_pkg::REG_FG: fg_ff <= pwdata[3:0];
            tcc_pkg::REG_BG: bg_ff <= pwdata[3:0];
            default: cols_ff <= cols_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         tcc_pkg::REG_COLUMNS: prdata = {23'd0, cols_ff};
         tcc_pkg::REG_ROWS: prdata = {24'd0, rows_ff};
         tcc_pkg::REG_FG: prdata = {28'd0, fg_ff};
         tcc_pkg::REG_BG: prdata = {28'd0, bg_ff};
         default: prdata = '0;
      endcase
   end

   // Hold the screen size within what the cursor can address
   always_comb begin
      if (cols_ff == 9'd0) begin
         cols_eff = 9'd1;
      end else if (cols_ff > COL_LIMIT_V) begin
         cols_eff = COL_LIMIT_V;
      end else begin
         cols_eff = cols_ff;
      end
      if (rows_ff == 8'd0) begin
         rows_eff = 8'd1;
      end else if (rows_ff > ROW_LIMIT_V) begin
         rows_eff = ROW_LIMIT_V;
      end else begin
         rows_eff = rows_ff;
      end
   end

   // Take a request only while the queue can hold two more results
   assign req_stall = fifo_count > tcc_pkg::FIFO_CNT_W'(tcc_pkg::FIFO_DEPTH - 2);
   assign req_fire = req_valid & ~req_stall;
   assign rsp_valid = fifo_count != '0;
   assign rsp_fire = rsp_valid & ~rsp_stall;
   assign push_count = req_fire ? step.count : 2'd0;

   tcc_step u_step (
      .req_type   (req_type),
      .char_code  (req_char_code),
      .target_col (req_target_col),
      .target_row (req_target_row),
      .cur_col    (cur_col_ff),
      .cur_row    (cur_row_ff),
      .cols_eff   (cols_eff),
      .rows_eff   (rows_eff),
      .fg_idx     (fg_ff),
      .bg_idx     (bg_ff),
      .step       (step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= 8'd0;
         cur_row_ff <= 7'd0;
      end else if (req_fire) begin
         cur_col_ff <= step.col;
         cur_row_ff <= step.row;
      end
   end

   tcc_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (step.first),
      .push_second (step.second),
      .pop         (rsp_fire),
      .count       (fifo_count),
      .head        (head)
   );

   assign rsp_action = head.action;
   assign rsp_cell_col = head.cell_col;
   assign rsp_cell_row = head.cell_row;
   assign rsp_glyph_code = head.glyph_code;
   assign rsp_fg_rgb = head.fg_rgb;
   assign rsp_bg_rgb = head.bg_rgb;
   assign rsp_last = head.last;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= tcc_pkg::FIFO_CNT_W'(tcc_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == tcc_pkg::REQ_CLEAR |=> cur_col_ff == 8'd0 && cur_row_ff == 7'd0)
      else $error("clear did not home the cursor");

   a_write_row_inside: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == tcc_pkg::REQ_WRITE && req_char_code == tcc_pkg::CHAR_NEWLINE
      |=> {1'b0, cur_row_ff} < $past(rows_eff))
      else $error("newline left the cursor below the screen");

   a_set_inside: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == tcc_pkg::REQ_SET_CURSOR
      |=> {1'b0, cur_col_ff} < $past(cols_eff) && {1'b0, cur_row_ff} < $past(rows_eff))
      else $error("set cursor left the cursor outside the screen");

   a_non_draw_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != tcc_pkg::ACT_DRAW |-> rsp_last)
      else $error("scroll or clear result not marked last");

endmodule

>>> tb/sv/tb_text_console_cursor_controller.sv
module tb_text_console_cursor_controller;

   // Request codes the block must ignore
   localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] REQ_RESERVED_LAST = 3'd7;

   // 16-entry CGA palette, index 0 in the low slot
   localparam logic [15:0][23:0] CGA_RGB = {
      24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
      24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
      24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
      24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
   };

   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 110;
   localparam int PHASES = 10;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  ch;
      logic [15:0] col;
      logic [15:0] row;
   } console_cmd_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_type = tcc_pkg::REQ_WRITE;
   logic [7:0]         req_char_code = '0;
   logic signed [15:0] req_target_col = '0;
   logic signed [15:0] req_target_row = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_action;
   logic [7:0]         rsp_cell_col;
   logic [6:0]         rsp_cell_row;
   logic [7:0]         rsp_glyph_code;
   logic [23:0]        rsp_fg_rgb;
   logic [23:0]        rsp_bg_rgb;
   logic               rsp_last;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   text_console_cursor_controller u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_glyph_code (rsp_glyph_code),
      .rsp_fg_rgb     (rsp_fg_rgb),
      .rsp_bg_rgb     (rsp_bg_rgb),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Cursor tracker state and its copy of the registers
   logic [8:0] cfg_cols = tcc_pkg::COLUMNS_RESET;
   logic [7:0] cfg_rows = tcc_pkg::ROWS_RESET;
   logic [3:0] fg_idx = tcc_pkg::FG_RESET;
   logic [3:0] bg_idx = tcc_pkg::BG_RESET;
   logic [7:0] cur_col = '0;
   logic [6:0] cur_row = '0;

   console_cmd_type  cmd_backlog[$];
   tcc_pkg::rsp_type step_out[$];
   tcc_pkg::rsp_type due_actions[$];
   console_cmd_type  next_cmd;
   tcc_pkg::rsp_type seen;
   tcc_pkg::rsp_type want;

   int  req_pushed = 0;
   int  req_taken_cnt = 0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp_go = 1'b0;
   bit  rsp_block = 1'b0;
   int  mismatches = 0;
   int  n_draw = 0;
   int  n_scroll = 0;
   int  n_clear = 0;
   int  n_settings = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int cols_in_use();
      int c;
      c = int'(cfg_cols);
      if (c < 1) c = 1;
      if (c > tcc_pkg::COL_LIMIT) c = tcc_pkg::COL_LIMIT;
      return c;
   endfunction

   function automatic int rows_in_use();
      int r;
      r = int'(cfg_rows);
      if (r < 1) r = 1;
      if (r > tcc_pkg::ROW_LIMIT) r = tcc_pkg::ROW_LIMIT;
      return r;
   endfunction

   function automatic void emit(input logic [1:0] act, input logic [7:0] col,
                                input logic [6:0] row, input logic [7:0] glyph,
                                input logic [23:0] fg, input logic [23:0] bg);
      tcc_pkg::rsp_type r;
      r = '0;
      r.action = act;
      r.cell_col = col;
      r.cell_row = row;
      r.glyph_code = glyph;
      r.fg_rgb = fg;
      r.bg_rgb = bg;
      step_out.push_back(r);
   endfunction

   // No cell is drawn while the cursor sits outside a shrunken screen
   function automatic void draw_cell(input logic [7:0] glyph);
      if (int'(cur_col) >= cols_in_use() || int'(cur_row) >= rows_in_use())
         return;
      emit(tcc_pkg::ACT_DRAW, cur_col, cur_row, glyph, CGA_RGB[fg_idx], CGA_RGB[bg_idx]);
   endfunction

   function automatic void line_feed();
      int r;
      r = int'(cur_row) + 1;
      cur_col = '0;
      if (r >= rows_in_use()) begin
         emit(tcc_pkg::ACT_SCROLL, '0, '0, '0, '0, '0);
         r = rows_in_use() - 1;
      end
      cur_row = r[6:0];
   endfunction

   function automatic void track_cursor(input console_cmd_type cmd);
      int x;
      int y;
      case (cmd.kind)
         tcc_pkg::REQ_WRITE: begin
            if (cmd.ch == tcc_pkg::CHAR_NEWLINE) begin
               line_feed();
            end else begin
               draw_cell(cmd.ch);
               x = int'(cur_col) + 1;
               if (x >= cols_in_use()) line_feed();
               else cur_col = x[7:0];
            end
         end
         tcc_pkg::REQ_BACKSPACE: begin
            if (cur_col != 8'd0) begin
               cur_col = cur_col - 8'd1;
               draw_cell(tcc_pkg::CHAR_SPACE);
            end
         end
         tcc_pkg::REQ_ERASE: draw_cell(tcc_pkg::CHAR_SPACE);
         tcc_pkg::REQ_CLEAR: begin
            emit(tcc_pkg::ACT_CLEAR, '0, '0, '0, '0, '0);
            cur_col = '0;
            cur_row = '0;
         end
         tcc_pkg::REQ_SET_CURSOR: begin
            x = int'($signed(cmd.col));
            y = int'($signed(cmd.row));
            if (x < 0) x = 0;
            if (y < 0) y = 0;
            if (x >= cols_in_use()) x = cols_in_use() - 1;
            if (y >= rows_in_use()) y = rows_in_use() - 1;
            cur_col = x[7:0];
            cur_row = y[6:0];
         end
         default: ;
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      while (step_out.size() > 0) due_actions.push_back(step_out.pop_front());
   endfunction

   function automatic int pick_gap();
      int p;
      if (!idle_on) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_cmd(input logic [2:0] kind, input logic [7:0] ch,
                                     input logic [15:0] col, input logic [15:0] row);
      console_cmd_type cmd;
      cmd.kind = kind;
      cmd.ch = ch;
      cmd.col = col;
      cmd.row = row;
      cmd_backlog.push_back(cmd);
      req_pushed++;
   endfunction

   function automatic void queue_random_cmd();
      int p;
      int q;
      logic [2:0] kind;
      logic [7:0] ch;
      logic [15:0] col;
      logic [15:0] row;
      p = $urandom_range(0, 99);
      ch = 8'($urandom_range(0, 255));
      col = 16'($urandom);
      row = 16'($urandom);
      if (p < 55) begin
         kind = tcc_pkg::REQ_WRITE;
         if ($urandom_range(0, 9) == 0) ch = tcc_pkg::CHAR_NEWLINE;
      end else if (p < 65) begin
         kind = tcc_pkg::REQ_BACKSPACE;
      end else if (p < 75) begin
         kind = tcc_pkg::REQ_ERASE;
      end else if (p < 79) begin
         kind = tcc_pkg::REQ_CLEAR;
      end else if (p < 97) begin
         kind = tcc_pkg::REQ_SET_CURSOR;
         q = $urandom_range(0, 3);
         // aim mostly at or near the screen, some just outside it, so writes wrap and scroll often
         if (q < 2) begin
            col = 16'($urandom_range(0, cols_in_use() + 4) - 2);
            row = 16'($urandom_range(0, rows_in_use() + 4) - 2);
         end else if (q == 2) begin
            col = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            row = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         end
      end else begin
         kind = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
      end
      queue_cmd(kind, ch, col, row);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
   endtask

   // Request driver: advance only once the current request was taken
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (cmd_backlog.size() > 0) begin
            next_cmd = cmd_backlog.pop_front();
            req_valid <= 1'b1;
            req_type <= next_cmd.kind;
            req_char_code <= next_cmd.ch;
            req_target_col <= next_cmd.col;
            req_target_row <= next_cmd.row;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus the long hold-off
   always @(negedge clock) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else stall_left = pick_gap();
      rsp_stall <= rsp_block || (stall_left > 0);
   end

   initial begin
      wait (hold_rsp_go);
      @(posedge clock);
      rsp_block = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_block = 1'b0;
   end

   // Monitor: check results first, then track the request taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.action = rsp_action;
            seen.cell_col = rsp_cell_col;
            seen.cell_row = rsp_cell_row;
            seen.glyph_code = rsp_glyph_code;
            seen.fg_rgb = rsp_fg_rgb;
            seen.bg_rgb = rsp_bg_rgb;
            seen.last = rsp_last;
            case (rsp_action)
               tcc_pkg::ACT_DRAW: n_draw++;
               tcc_pkg::ACT_SCROLL: n_scroll++;
               default: n_clear++;
            endcase
            if (due_actions.size() == 0) begin
               report_mismatch("result with nothing outstanding, action",
                               32'(seen.action), '0);
            end else begin
               want = due_actions.pop_front();
               if (seen.action !== want.action)
                  report_mismatch("action", 32'(seen.action), 32'(want.action));
               if (seen.cell_col !== want.cell_col)
                  report_mismatch("cell_col", 32'(seen.cell_col), 32'(want.cell_col));
               if (seen.cell_row !== want.cell_row)
                  report_mismatch("cell_row", 32'(seen.cell_row), 32'(want.cell_row));
               if (seen.glyph_code !== want.glyph_code)
                  report_mismatch("glyph_code", 32'(seen.glyph_code), 32'(want.glyph_code));
               if (seen.fg_rgb !== want.fg_rgb)
                  report_mismatch("fg_rgb", 32'(seen.fg_rgb), 32'(want.fg_rgb));
               if (seen.bg_rgb !== want.bg_rgb)
                  report_mismatch("bg_rgb", 32'(seen.bg_rgb), 32'(want.bg_rgb));
               if (seen.last !== want.last)
                  report_mismatch("last", 32'(seen.last), 32'(want.last));
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            track_cursor({req_type, req_char_code, req_target_col, req_target_row});
            req_taken_cnt++;
         end
      end
   end

   task automatic wait_idle();
      while (req_taken_cnt != req_pushed || due_actions.size() != 0) @(negedge clock);
      // requests without results may still be in flight
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         tcc_pkg::REG_COLUMNS: cfg_cols = value[8:0];
         tcc_pkg::REG_ROWS: cfg_rows = value[7:0];
         tcc_pkg::REG_FG: fg_idx = value[3:0];
         default: bg_idx = value[3:0];
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_screen(input int cols, input int rows, input int fg, input int bg);
      csr_write(tcc_pkg::REG_COLUMNS, cols);
      csr_write(tcc_pkg::REG_ROWS, rows);
      csr_write(tcc_pkg::REG_FG, fg);
      csr_write(tcc_pkg::REG_BG, bg);
      n_settings++;
   endtask

   initial begin
      int cols;
      int rows;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests on the reset screen size
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h41, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_BACKSPACE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_ERASE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, tcc_pkg::CHAR_NEWLINE, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_BACKSPACE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'h8000, 16'h8000);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'h7FFF, 16'h7FFF);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h7E, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, tcc_pkg::CHAR_NEWLINE, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'h5555, 16'hAAAA);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'hAAAA, 16'h5555);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h55, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'hAA, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_CLEAR, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(REQ_RESERVED_FIRST, 8'hFF, 16'h7FFF, 16'h7FFF);
      queue_cmd(REQ_RESERVED_FIRST + 3'd1, 8'h41, 16'h0001, 16'h0001);
      queue_cmd(REQ_RESERVED_LAST, 8'h20, 16'h8000, 16'h8000);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'd5, 16'd3);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h80, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_SET_CURSOR, 8'h00, 16'd100, 16'd40);
      wait_idle();

      // shrink the screen under the cursor
      set_screen(10, 5, 4, 1);
      queue_cmd(tcc_pkg::REQ_ERASE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_BACKSPACE, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h78, 16'h0000, 16'h0000);
      queue_cmd(tcc_pkg::REQ_WRITE, 8'h79, 16'h0000, 16'h0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         idle_on = !(ph == 5 || ph == 8);
         case (ph)
            0: begin cols = 256; rows = 128; end
            1: begin cols = 1; rows = 1; end
            2: begin cols = 0; rows = 0; end
            3: begin cols = 511; rows = 255; end
            4: begin cols = 2; rows = 3; end
            5: begin cols = 80; rows = 25; end
            default: begin
               cols = $urandom_range(1, 16);
               rows = $urandom_range(1, 8);
               if ($urandom_range(0, 3) == 0) begin
                  cols = $urandom_range(0, 511);
                  rows = $urandom_range(0, 255);
               end
            end
         endcase
         if (ph == 0) set_screen(cols, rows, 0, 15);
         else if (ph == 1) set_screen(cols, rows, 15, 0);
         else set_screen(cols, rows, $urandom_range(0, 15), $urandom_range(0, 15));
         // hold the receiver while requests keep coming so the block backs up
         if (ph == 5) hold_rsp_go = 1'b1;
         repeat (PHASE_ITEMS) queue_random_cmd();
      end

      wait_idle();
      repeat (10) @(negedge clock);
      $display("covered %0d requests over %0d screen settings", req_pushed, n_settings + 1);
      $display("results seen: %0d draws, %0d scrolls, %0d clears", n_draw, n_scroll, n_clear);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(12 * 800000);
      $display("timeout with %0d results outstanding", due_actions.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
